// File: rtl/core/raf_pkg.sv
// Shared types, codes and helpers for the rotational anisotropy field block.
// No dependencies; imported by every module under rtl/core.
package raf_pkg;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [2:0] SEL_FX = 3'd0;
    localparam logic [2:0] SEL_FY = 3'd1;
    localparam logic [2:0] SEL_FZ = 3'd2;
    localparam logic [2:0] SEL_GX = 3'd3;
    localparam logic [2:0] SEL_GY = 3'd4;
    localparam logic [2:0] SEL_GZ = 3'd5;
    localparam logic [2:0] SEL_K  = 3'd6;

    // rounding offsets, half an LSB of the dropped bits
    localparam int HALF13 = 1 << 12;
    localparam int HALF15 = 1 << 14;
    localparam int HALF30 = 1 << 29;

    typedef logic signed [15:0] t_q15;
    typedef logic signed [31:0] t_q16;
    typedef logic signed [17:0] t_proj;
    typedef logic signed [41:0] t_corr;

    typedef struct packed {
        t_q15 f_x;
        t_q15 f_y;
        t_q15 f_z;
        t_q15 g_x;
        t_q15 g_y;
        t_q15 g_z;
        t_q16 k;
    } t_words;

    typedef struct packed {
        t_words w;
        t_q16   fin_x;
        t_q16   fin_y;
        t_q16   fin_z;
        logic   last;
    } t_frame;

    function automatic t_q16 sat32(input logic signed [63:0] v);
        t_q16 r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/raf_table.sv
// Per-material table: axes (Q1.15, saturated on write) and k (Q16.16).
// One memory per word, registered read; depends on raf_pkg.
module raf_table
    import raf_pkg::*;
#(
    parameter int MATERIALS = 4
) (
    input  logic       i_clk,
    input  logic       i_wr_en,
    input  logic       i_rd_en,
    input  logic [1:0] i_material,
    input  logic [2:0] i_word_select,
    input  t_q16       i_word_value,
    output t_words     o_words
);

    localparam int AW = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;

    logic [AW-1:0] addr;
    logic          in_range;
    t_q15          axis_val;

    t_q15   r_mem_fx [MATERIALS];
    t_q15   r_mem_fy [MATERIALS];
    t_q15   r_mem_fz [MATERIALS];
    t_q15   r_mem_gx [MATERIALS];
    t_q15   r_mem_gy [MATERIALS];
    t_q15   r_mem_gz [MATERIALS];
    t_q16   r_mem_k  [MATERIALS];
    t_words r_rd;
    logic   r_in_range;

    assign addr     = AW'(i_material);
    assign in_range = int'(i_material) < MATERIALS;

    always_comb begin
        if (i_word_value > 32'sd32767) begin
            axis_val = 16'sh7fff;
        end else if (i_word_value < -32'sd32768) begin
            axis_val = 16'sh8000;
        end else begin
            axis_val = i_word_value[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            unique case (i_word_select)
                SEL_FX:  r_mem_fx[addr] <= axis_val;
                SEL_FY:  r_mem_fy[addr] <= axis_val;
                SEL_FZ:  r_mem_fz[addr] <= axis_val;
                SEL_GX:  r_mem_gx[addr] <= axis_val;
                SEL_GY:  r_mem_gy[addr] <= axis_val;
                SEL_GZ:  r_mem_gz[addr] <= axis_val;
                SEL_K:   r_mem_k[addr]  <= i_word_value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.f_x   <= r_mem_fx[addr];
            r_rd.f_y   <= r_mem_fy[addr];
            r_rd.f_z   <= r_mem_fz[addr];
            r_rd.g_x   <= r_mem_gx[addr];
            r_rd.g_y   <= r_mem_gy[addr];
            r_rd.g_z   <= r_mem_gz[addr];
            r_rd.k     <= r_mem_k[addr];
            r_in_range <= in_range;
        end
    end

    // material beyond the table reads as all-zero words
    assign o_words = r_in_range ? r_rd : '0;

endmodule

// File: rtl/core/raf_proj.sv
// Projection stage: spin onto the local x and y axes, rounded to Q.15.
// Builds the frame carried down the pipeline; depends on raf_pkg.
module raf_proj
    import raf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_valid,
    input  t_q15   i_spin_x,
    input  t_q15   i_spin_y,
    input  t_q15   i_spin_z,
    input  t_words i_words,
    input  t_q16   i_fin_x,
    input  t_q16   i_fin_y,
    input  t_q16   i_fin_z,
    input  logic   i_last,
    output logic   o_valid,
    output t_proj  o_sx,
    output t_proj  o_sy,
    output t_frame o_frame
);

    logic signed [31:0] p_fx, p_fy, p_fz, p_gx, p_gy, p_gz;
    logic signed [34:0] sum_f, sum_g;

    logic   r_valid;
    t_proj  r_sx, r_sy;
    t_frame r_frame;

    assign p_fx = 32'(i_spin_x) * 32'(i_words.f_x);
    assign p_fy = 32'(i_spin_y) * 32'(i_words.f_y);
    assign p_fz = 32'(i_spin_z) * 32'(i_words.f_z);
    assign p_gx = 32'(i_spin_x) * 32'(i_words.g_x);
    assign p_gy = 32'(i_spin_y) * 32'(i_words.g_y);
    assign p_gz = 32'(i_spin_z) * 32'(i_words.g_z);

    assign sum_f = 35'(p_fx) + 35'(p_fy) + 35'(p_fz) + 35'(HALF15);
    assign sum_g = 35'(p_gx) + 35'(p_gy) + 35'(p_gz) + 35'(HALF15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sx          <= 18'(sum_f >>> 15);
            r_sy          <= 18'(sum_g >>> 15);
            r_frame.w     <= i_words;
            r_frame.fin_x <= i_fin_x;
            r_frame.fin_y <= i_fin_y;
            r_frame.fin_z <= i_fin_z;
            r_frame.last  <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;
    assign o_frame = r_frame;

endmodule

// File: rtl/core/raf_poly.sv
// Six-stage polynomial pipeline: squares, cubic terms, k scaling, energy.
// Produces the x/y corrections in Q26.16 and the saturated energy; depends on raf_pkg.
module raf_poly
    import raf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_valid,
    input  t_proj  i_sx,
    input  t_proj  i_sy,
    input  t_frame i_frame,
    output logic   o_valid,
    output t_corr  o_cx,
    output t_corr  o_cy,
    output t_q16   o_energy,
    output t_frame o_frame
);

    logic signed [55:0] neg_e;

    logic [5:0] r_vld;
    t_frame     r_frm [6];

    logic signed [34:0] r_a, r_b;
    logic signed [35:0] r_q;
    t_proj              r_sx1, r_sy1, r_sx2, r_sy2;
    logic signed [35:0] r_u, r_v, r_d;
    logic signed [19:0] r_m;
    logic signed [55:0] r_ptx, r_pty, r_pte;
    logic signed [22:0] r_tx, r_ty, r_te;
    logic signed [54:0] r_pkx, r_pky, r_pke;
    t_corr              r_cx, r_cy;
    t_q16               r_energy;

    assign neg_e = -56'(r_pke) + 56'(HALF13);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_frm[0] <= i_frame;
            for (int i = 1; i < 6; i++) begin
                r_frm[i] <= r_frm[i-1];
            end
            // squares and cross term (Q.30)
            r_a   <= 35'(i_sx) * 35'(i_sx);
            r_b   <= 35'(i_sy) * 35'(i_sy);
            r_q   <= 36'(i_sx) * 36'(i_sy);
            r_sx1 <= i_sx;
            r_sy1 <= i_sy;
            // 3a-b, a-3b, a-b, rounded Sx*Sy
            r_u   <= (36'(r_a) <<< 1) + 36'(r_a) - 36'(r_b);
            r_v   <= 36'(r_a) - (36'(r_b) <<< 1) - 36'(r_b);
            r_d   <= 36'(r_a) - 36'(r_b);
            r_m   <= 20'((r_q + 36'(HALF15)) >>> 15);
            r_sx2 <= r_sx1;
            r_sy2 <= r_sy1;
            // cubic products
            r_ptx <= 56'(r_sy2) * 56'(r_u);
            r_pty <= 56'(r_sx2) * 56'(r_v);
            r_pte <= 56'(r_m) * 56'(r_d);
            // back to Q.15
            r_tx  <= 23'((r_ptx + 56'(HALF30)) >>> 30);
            r_ty  <= 23'((r_pty + 56'(HALF30)) >>> 30);
            r_te  <= 23'((r_pte + 56'(HALF30)) >>> 30);
            // times k; the factor four is folded into the final shift
            r_pkx <= 55'(r_frm[3].w.k) * 55'(r_tx);
            r_pky <= 55'(r_frm[3].w.k) * 55'(r_ty);
            r_pke <= 55'(r_frm[3].w.k) * 55'(r_te);
            r_cx     <= 42'((r_pkx + 55'(HALF13)) >>> 13);
            r_cy     <= 42'((r_pky + 55'(HALF13)) >>> 13);
            r_energy <= sat32(64'(neg_e >>> 13));
        end
    end

    assign o_valid  = r_vld[5];
    assign o_cx     = r_cx;
    assign o_cy     = r_cy;
    assign o_energy = r_energy;
    assign o_frame  = r_frm[5];

endmodule

// File: rtl/core/raf_apply.sv
// Field update: projects the corrections back onto the axes and, while enabled, adds them.
// Ends in the output register; depends on raf_pkg.
module raf_apply
    import raf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_enable,
    input  logic   i_valid,
    input  t_corr  i_cx,
    input  t_corr  i_cy,
    input  t_q16   i_energy,
    input  t_frame i_frame,
    output logic   o_valid,
    output t_q16   o_field_x,
    output t_q16   o_field_y,
    output t_q16   o_field_z,
    output t_q16   o_energy,
    output logic   o_last
);

    logic [2:0] r_vld;
    t_frame     r_fr1, r_fr2;
    t_q16       r_e1, r_e2;

    logic signed [57:0] r_pfx, r_pfy, r_pfz, r_pgx, r_pgy, r_pgz;
    logic signed [43:0] r_hx, r_hy, r_hz;
    t_q16               r_out_fx, r_out_fy, r_out_fz, r_out_e;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fr1 <= i_frame;
            r_e1  <= i_energy;
            r_pfx <= 58'(i_cx) * 58'(i_frame.w.f_x);
            r_pfy <= 58'(i_cx) * 58'(i_frame.w.f_y);
            r_pfz <= 58'(i_cx) * 58'(i_frame.w.f_z);
            r_pgx <= 58'(i_cy) * 58'(i_frame.w.g_x);
            r_pgy <= 58'(i_cy) * 58'(i_frame.w.g_y);
            r_pgz <= 58'(i_cy) * 58'(i_frame.w.g_z);

            r_fr2 <= r_fr1;
            r_e2  <= r_e1;
            r_hx  <= 44'((59'(r_pfx) + 59'(r_pgx) + 59'(HALF15)) >>> 15);
            r_hy  <= 44'((59'(r_pfy) + 59'(r_pgy) + 59'(HALF15)) >>> 15);
            r_hz  <= 44'((59'(r_pfz) + 59'(r_pgz) + 59'(HALF15)) >>> 15);

            if (i_enable) begin
                r_out_fx <= sat32(64'(r_fr2.fin_x) + 64'(r_hx));
                r_out_fy <= sat32(64'(r_fr2.fin_y) + 64'(r_hy));
                r_out_fz <= sat32(64'(r_fr2.fin_z) + 64'(r_hz));
            end else begin
                r_out_fx <= r_fr2.fin_x;
                r_out_fy <= r_fr2.fin_y;
                r_out_fz <= r_fr2.fin_z;
            end
            r_out_e    <= r_e2;
            r_out_last <= r_fr2.last;
        end
    end

    assign o_valid   = r_vld[2];
    assign o_field_x = r_out_fx;
    assign o_field_y = r_out_fy;
    assign o_field_z = r_out_fz;
    assign o_energy  = r_out_e;
    assign o_last    = r_out_last;

endmodule

// File: rtl/core/rotational_anisotropy_field.sv
// Top level of the fourth-order rotational anisotropy field block.
// Instantiates raf_table, raf_proj, raf_poly and raf_apply; depends on raf_pkg.
//
// Takes one request per cycle whenever the output is taken; each accepted atom goes through
// an input register with the table read, one projection stage, six polynomial
// stages and three field-update stages ending in the output register. The whole pipeline
// advances together and holds while a result waits with m_axis_tready low, so throughput is
// one atom per cycle whenever the output is taken. Requests with tuser 0 load one table word
// (material, word_select, word_value) and give no result; write every word of a material
// before evaluating atoms of it. The user writes the enable register only while the pipeline
// is empty (not enforced); with it clear fields pass through and energy is still computed.
module rotational_anisotropy_field
    import raf_pkg::*;
#(
    parameter int MATERIALS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,   // enable
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // material[1:0], word_select[4:2], word_value[36:5], spin_x[52:37], spin_y[68:53],
    // spin_z[84:69], field_x_in[116:85], field_y_in[148:117], field_z_in[180:149], pad
    input  logic [183:0] s_axis_tdata,
    input  logic         s_axis_tuser,    // func
    input  logic         s_axis_tlast,    // last_atom
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // field_x_out[31:0], field_y_out[63:32], field_z_out[95:64], energy[127:96]
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast     // last_out
);

    logic   adv, acc;
    t_words words;
    logic   proj_valid, poly_valid;
    t_proj  proj_sx, proj_sy;
    t_frame proj_frame, poly_frame;
    t_corr  poly_cx, poly_cy;
    t_q16   poly_energy;
    t_q16   out_fx, out_fy, out_fz, out_e;

    logic r_enable;
    logic r_s0_valid;
    t_q15 r_s0_sx, r_s0_sy, r_s0_sz;
    t_q16 r_s0_fx, r_s0_fy, r_s0_fz;
    logic r_s0_last;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_s0_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (adv) begin
                r_s0_valid <= acc && (s_axis_tuser == FUNC_EVAL);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_sx   <= s_axis_tdata[52:37];
            r_s0_sy   <= s_axis_tdata[68:53];
            r_s0_sz   <= s_axis_tdata[84:69];
            r_s0_fx   <= s_axis_tdata[116:85];
            r_s0_fy   <= s_axis_tdata[148:117];
            r_s0_fz   <= s_axis_tdata[180:149];
            r_s0_last <= s_axis_tlast;
        end
    end

    raf_table #(
        .MATERIALS(MATERIALS)
    ) u_table (
        .i_clk        (i_clk),
        .i_wr_en      (acc && (s_axis_tuser == FUNC_LOAD)),
        .i_rd_en      (adv),
        .i_material   (s_axis_tdata[1:0]),
        .i_word_select(s_axis_tdata[4:2]),
        .i_word_value (s_axis_tdata[36:5]),
        .o_words      (words)
    );

    raf_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s0_valid),
        .i_spin_x(r_s0_sx),
        .i_spin_y(r_s0_sy),
        .i_spin_z(r_s0_sz),
        .i_words (words),
        .i_fin_x (r_s0_fx),
        .i_fin_y (r_s0_fy),
        .i_fin_z (r_s0_fz),
        .i_last  (r_s0_last),
        .o_valid (proj_valid),
        .o_sx    (proj_sx),
        .o_sy    (proj_sy),
        .o_frame (proj_frame)
    );

    raf_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (proj_valid),
        .i_sx    (proj_sx),
        .i_sy    (proj_sy),
        .i_frame (proj_frame),
        .o_valid (poly_valid),
        .o_cx    (poly_cx),
        .o_cy    (poly_cy),
        .o_energy(poly_energy),
        .o_frame (poly_frame)
    );

    raf_apply u_apply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_enable (r_enable),
        .i_valid  (poly_valid),
        .i_cx     (poly_cx),
        .i_cy     (poly_cy),
        .i_energy (poly_energy),
        .i_frame  (poly_frame),
        .o_valid  (m_axis_tvalid),
        .o_field_x(out_fx),
        .o_field_y(out_fy),
        .o_field_z(out_fz),
        .o_energy (out_e),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_e, out_fz, out_fy, out_fx};

endmodule

// File: test/tb_rotational_anisotropy_field.sv
// Self-checking testbench for rotational_anisotropy_field: material table loads and atom
// evaluations over the stream ports, checked against an in-bench fixed-point predictor.
// Depends on raf_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_rotational_anisotropy_field;
    import raf_pkg::*;

    localparam int RANDOM_ITEMS_PER_PHASE = 190;
    localparam int NUM_PHASES = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT_RESULT = 250;
    localparam int HOLD_CYCLES = 300;
    localparam logic [2:0] SEL_NONE = 3'd7;
    localparam t_q16 Q16_MAX = 32'sh7fffffff;
    localparam t_q16 Q16_MIN = 32'sh80000000;

    typedef struct packed {
        logic       func;
        logic [1:0] material;
        logic [2:0] sel;
        t_q16       value;
        t_q15       spin_x;
        t_q15       spin_y;
        t_q15       spin_z;
        t_q16       fin_x;
        t_q16       fin_y;
        t_q16       fin_z;
        logic       last;
    } t_atom_req;

    typedef struct packed {
        t_q16 field_x;
        t_q16 field_y;
        t_q16 field_z;
        t_q16 energy;
        logic last;
    } t_atom_res;

    typedef struct packed {
        t_atom_req req;
        logic      typed;
        t_atom_res res;
    } t_stim_row;

    localparam int NUM_DIRECTED = 25;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic         i_cfg_wr_data = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;

    rotational_anisotropy_field #(.MATERIALS(4)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] material_tab [0:3][0:6];
    logic [6:0]         written [0:3];
    logic               enable_q;

    t_atom_res pending_fields [$];
    t_stim_row directed_rows [NUM_DIRECTED];
    int        errors = 0;
    int        cycle_count = 0;
    int        results_seen = 0;
    logic      tx_burst = 1'b0;
    logic      rx_burst = 1'b0;
    logic      hold_done = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint round_shift(longint v, int s);
        longint w;
        w = v + (longint'(1) <<< (s - 1));
        return w >>> s;
    endfunction

    function automatic t_q16 clamp_q16(longint v);
        if (v > 64'sd2147483647) return Q16_MAX;
        if (v < -64'sd2147483648) return Q16_MIN;
        return t_q16'(v);
    endfunction

    function automatic t_atom_res predict_atom(t_atom_req r);
        longint w [0:6];
        longint s0, s1, s2, sx, sy, a, b, k4, tx, ty, cx, cy, m, te;
        longint fin [0:2];
        t_atom_res o;
        for (int i = 0; i < 7; i++) w[i] = longint'(material_tab[r.material][i]);
        s0 = longint'(r.spin_x);
        s1 = longint'(r.spin_y);
        s2 = longint'(r.spin_z);
        fin[0] = longint'(r.fin_x);
        fin[1] = longint'(r.fin_y);
        fin[2] = longint'(r.fin_z);
        sx = round_shift(s0 * w[0] + s1 * w[1] + s2 * w[2], 15);
        sy = round_shift(s0 * w[3] + s1 * w[4] + s2 * w[5], 15);
        a = sx * sx;
        b = sy * sy;
        k4 = 4 * w[6];
        tx = round_shift(sy * (3 * a - b), 30);
        ty = round_shift(sx * (a - 3 * b), 30);
        cx = round_shift(k4 * tx, 15);
        cy = round_shift(k4 * ty, 15);
        for (int i = 0; i < 3; i++) begin
            if (enable_q) fin[i] = fin[i] + round_shift(cx * w[i] + cy * w[3 + i], 15);
        end
        m = round_shift(sx * sy, 15);
        te = round_shift(m * (a - b), 30);
        o.field_x = clamp_q16(fin[0]);
        o.field_y = clamp_q16(fin[1]);
        o.field_z = clamp_q16(fin[2]);
        o.energy = clamp_q16(round_shift(-k4 * te, 15));
        o.last = r.last;
        return o;
    endfunction

    function automatic t_stim_row load_row(logic [1:0] mat, logic [2:0] sel, t_q16 val);
        t_stim_row row;
        row = '0;
        row.req.func = FUNC_LOAD;
        row.req.material = mat;
        row.req.sel = sel;
        row.req.value = val;
        return row;
    endfunction

    function automatic t_stim_row eval_row(t_q15 sx, t_q15 sy, t_q15 sz, t_q16 fx, t_q16 fy,
                                           t_q16 fz, logic last, logic typed, t_q16 energy);
        t_stim_row row;
        row = '0;
        row.req.func = FUNC_EVAL;
        row.req.spin_x = sx;
        row.req.spin_y = sy;
        row.req.spin_z = sz;
        row.req.fin_x = fx;
        row.req.fin_y = fy;
        row.req.fin_z = fz;
        row.req.last = last;
        row.typed = typed;
        row.res = '{fx, fy, fz, energy, last};
        return row;
    endfunction

    function automatic t_q15 rand_q15();
        case ($urandom_range(0, 4))
            0: return t_q15'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
            1: return t_q15'($signed($urandom_range(0, 2000)) - 1000);
            default: return t_q15'($urandom);
        endcase
    endfunction

    function automatic t_q16 rand_q16();
        case ($urandom_range(0, 4))
            0: return ($urandom_range(0, 1) == 0) ? Q16_MAX : Q16_MIN;
            1: return t_q16'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return t_q16'($urandom);
        endcase
    endfunction

    function automatic t_q16 rand_word(logic [2:0] sel);
        if (sel == SEL_K) begin
            if ($urandom_range(0, 3) != 0)
                return t_q16'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            return t_q16'($urandom);
        end
        if ($urandom_range(0, 3) != 0) return t_q16'($signed($urandom_range(0, 65535)) - 32768);
        return t_q16'($urandom);
    endfunction

    // book-keeping once a request has been taken
    task automatic apply_request(t_stim_row row);
        t_q16 v;
        if (row.req.func == FUNC_LOAD) begin
            if (row.req.sel <= SEL_K) begin
                v = row.req.value;
                if (row.req.sel != SEL_K) begin
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                end
                material_tab[row.req.material][row.req.sel] = v;
                written[row.req.material][row.req.sel] = 1'b1;
            end
        end else begin
            pending_fields.push_back(row.typed ? row.res : predict_atom(row.req));
        end
    endtask

    task automatic send_request(t_stim_row row);
        int gap;
        @(negedge i_clk);
        s_axis_tdata = {3'b000, row.req.fin_z, row.req.fin_y, row.req.fin_x, row.req.spin_z,
                        row.req.spin_y, row.req.spin_x, row.req.value, row.req.sel,
                        row.req.material};
        s_axis_tuser = row.req.func;
        s_axis_tlast = row.req.last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_request(row);
        if ($urandom_range(0, 40) == 0) tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = value;
        enable_q = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // random traffic: mostly evaluations of loaded materials, whole-material reloads,
    // and stray single-word loads
    task automatic random_phase();
        int        count;
        int        pick;
        int        start;
        t_stim_row row;
        logic [1:0] mat;
        count = 0;
        while (count < RANDOM_ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                mat = 2'($urandom_range(0, 3));
                start = $urandom_range(0, 6);
                for (int j = 0; j < 7; j++) begin
                    row = load_row(mat, 3'((start + j) % 7), '0);
                    row.req.value = rand_word(row.req.sel);
                    send_request(row);
                end
                count += 7;
            end else if (pick < 14) begin
                row = load_row(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                               t_q16'($urandom));
                row.req.spin_x = t_q15'($urandom);
                row.req.fin_y = t_q16'($urandom);
                row.req.last = 1'($urandom_range(0, 1));
                if (row.req.sel != SEL_NONE) row.req.value = rand_word(row.req.sel);
                send_request(row);
                if (row.req.sel != SEL_NONE) count++;
            end else begin
                do mat = 2'($urandom_range(0, 3)); while (written[mat] != 7'h7f);
                row = eval_row(rand_q15(), rand_q15(), rand_q15(), rand_q16(), rand_q16(),
                               rand_q16(), 1'($urandom_range(0, 1)), 1'b0, '0);
                row.req.material = mat;
                row.req.sel = 3'($urandom_range(0, 7));
                row.req.value = t_q16'($urandom);
                send_request(row);
                count++;
            end
        end
    endtask

    // result side
    initial begin
        t_atom_res got;
        t_atom_res want;
        int        wait_cycles;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
            wait_cycles = rx_burst ? 0 : $urandom_range(0, 8);
            if (!hold_done && results_seen == HOLD_AT_RESULT) begin
                wait_cycles = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            @(negedge i_clk);
            if (wait_cycles != 0) begin
                m_axis_tready = 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                    m_axis_tdata[127:96], m_axis_tlast};
            results_seen++;
            if (pending_fields.size() == 0) begin
                $error("result with nothing pending");
                errors++;
            end else begin
                want = pending_fields.pop_front();
                if (got.field_x !== want.field_x) begin
                    $error("field_x_out: expected %0d, actual %0d", want.field_x, got.field_x);
                    errors++;
                end
                if (got.field_y !== want.field_y) begin
                    $error("field_y_out: expected %0d, actual %0d", want.field_y, got.field_y);
                    errors++;
                end
                if (got.field_z !== want.field_z) begin
                    $error("field_z_out: expected %0d, actual %0d", want.field_z, got.field_z);
                    errors++;
                end
                if (got.energy !== want.energy) begin
                    $error("energy: expected %0d, actual %0d", want.energy, got.energy);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last_out: expected %0b, actual %0b", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int m = 0; m < 4; m++) begin
            written[m] = '0;
            for (int i = 0; i < 7; i++) material_tab[m][i] = '0;
        end
        enable_q = 1'b0;

        // axes saturate on load; zero k and zero spin leave the field untouched
        directed_rows[0]  = load_row(2'd0, SEL_FX, 32'sd40000);
        directed_rows[1]  = load_row(2'd0, SEL_FY, 32'sd0);
        directed_rows[2]  = load_row(2'd0, SEL_FZ, 32'sd0);
        directed_rows[3]  = load_row(2'd0, SEL_GX, 32'sd0);
        directed_rows[4]  = load_row(2'd0, SEL_GY, -32'sd100000);
        directed_rows[5]  = load_row(2'd0, SEL_GZ, 32'sd0);
        directed_rows[6]  = load_row(2'd0, SEL_K, 32'sd0);
        directed_rows[7]  = load_row(2'd0, SEL_NONE, 32'sd12345);
        directed_rows[8]  = eval_row(16'sh7fff, 16'sh8000, 16'sh7fff, Q16_MAX, Q16_MIN, 0,
                                     1'b1, 1'b1, 0);
        directed_rows[9]  = eval_row(16'sd0, 16'sd0, 16'sd0, Q16_MIN, Q16_MAX, -1,
                                     1'b0, 1'b1, 0);
        directed_rows[10] = load_row(2'd0, SEL_K, Q16_MAX);
        directed_rows[11] = eval_row(16'sd0, 16'sd0, 16'sd0, Q16_MAX, Q16_MIN, Q16_MAX,
                                     1'b1, 1'b1, 0);
        directed_rows[12] = eval_row(16'sh7fff, 16'sd0, 16'sd0, 0, 0, 0, 1'b0, 1'b0, 0);
        directed_rows[13] = eval_row(16'sh8000, 16'sh8000, 16'sh8000, Q16_MAX, Q16_MAX,
                                     Q16_MAX, 1'b0, 1'b0, 0);
        directed_rows[14] = eval_row(16'sd23170, -16'sd23170, 16'sd0, Q16_MIN, Q16_MIN,
                                     Q16_MIN, 1'b1, 1'b0, 0);
        directed_rows[15] = load_row(2'd0, SEL_K, Q16_MIN);
        directed_rows[16] = eval_row(16'sd23170, 16'sd23170, 16'sd100, 0, -1, 1, 1'b0, 1'b0, 0);
        directed_rows[17] = eval_row(16'sh8000, 16'sh7fff, -16'sd1, Q16_MAX, Q16_MIN, 0,
                                     1'b1, 1'b0, 0);
        directed_rows[18] = load_row(2'd0, SEL_FZ, 32'sd32767);
        directed_rows[19] = load_row(2'd0, SEL_GZ, -32'sd32768);
        directed_rows[20] = load_row(2'd0, SEL_K, 32'sh00010000);
        directed_rows[21] = eval_row(16'sd12000, -16'sd20000, 16'sd9000, 32'sd100000,
                                     -32'sd100000, 0, 1'b1, 1'b0, 0);
        directed_rows[22] = eval_row(-16'sd1, 16'sd1, 16'sh8000, 0, 0, 0, 1'b0, 1'b0, 0);
        directed_rows[23] = load_row(2'd0, SEL_NONE, Q16_MAX);
        directed_rows[24] = eval_row(16'sd5000, 16'sd5000, 16'sd5000, 0, 0, 0, 1'b1, 1'b0, 0);

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        cfg_write(1'b1);
        for (int r = 0; r < NUM_DIRECTED; r++) send_request(directed_rows[r]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            cfg_write(p[0]);
            random_phase();
        end
        drain();

        if (pending_fields.size() != 0) begin
            $error("%0d results never arrived", pending_fields.size());
            errors++;
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/raf_pkg.sv
rtl/core/raf_table.sv
rtl/core/raf_proj.sv
rtl/core/raf_poly.sv
rtl/core/raf_apply.sv
rtl/core/rotational_anisotropy_field.sv
test/tb_rotational_anisotropy_field.sv
